>>> rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

	// Field widths
	localparam int NUM_SENSORS = 4;
	localparam int IDX_W       = $clog2(NUM_SENSORS);
	localparam int SENSOR_W    = 2;
	localparam int ECHO_W      = 15;
	localparam int TIME_W      = 32;
	localparam int DIST_W      = 9;
	localparam int ON_W        = 10;
	localparam int IVL_W       = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;

	// Distance numerators over DIST_DEN: dur*343 and max*20000 both fit 24 bits
	localparam int NUM_W = 24;
	localparam logic [NUM_W-1:0] SOUND_NUM = 24'd343;
	localparam logic [NUM_W-1:0] DIST_DEN  = 24'd20000;

	// Divide by 20000 as (n >> 5) * ceil(2^29 / 625) >> 29, exact for n >> 5 below 2^19
	localparam int DEN_SH  = 5;
	localparam int RCP_W   = 20;
	localparam int RCP_SH  = 29;
	localparam int QPROD_W = NUM_W - DEN_SH + RCP_W;
	localparam logic [RCP_W-1:0] RCP_625 = 20'd858994;

	// Interval mapping: |floor*(hi-lo)| < 2^20, signed sum needs 22 bits
	localparam int MAG_W  = 20;
	localparam int MAP_W  = 22;
	localparam int DCNT_W = $clog2(MAG_W);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register reset values
	localparam logic [DIST_W-1:0] WARNING_RST = 9'd150;
	localparam logic [DIST_W-1:0] MAXDIST_RST = 9'd200;
	localparam logic [ON_W-1:0]   BEEP_ON_RST = 10'd50;
	localparam logic [IVL_W-1:0]  IVL_MIN_RST = 11'd30;
	localparam logic [IVL_W-1:0]  IVL_MAX_RST = 11'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WARNING  = 3'd0,
		REG_MAXDIST  = 3'd1,
		REG_BEEP_ON  = 3'd2,
		REG_IVL_MIN  = 3'd3,
		REG_IVL_MAX  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0] warn_limit_cm;
		logic [DIST_W-1:0] range_cap_cm;
		logic [ON_W-1:0]   beep_on_ms;
		logic [IVL_W-1:0]  interval_min_ms;
		logic [IVL_W-1:0]  interval_max_ms;
	} cfg_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [DIST_W-1:0]   floor_cm;
		logic [SENSOR_W-1:0] sensor;
		logic                silent;
	} job_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_SCAN,
		FE_DIV,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_MUL,
		BE_DIV,
		BE_MAP,
		BE_TIMER
	} be_state_t;

endpackage

`default_nettype wire

>>> rtl/pba_if.sv
`default_nettype none

interface pba_in_if;
	logic                        valid;
	logic                        ready;
	logic [pba_pkg::ECHO_W-1:0]  echo_front_us;
	logic [pba_pkg::ECHO_W-1:0]  echo_left_us;
	logic [pba_pkg::ECHO_W-1:0]  echo_right_us;
	logic [pba_pkg::ECHO_W-1:0]  echo_top_us;
	logic [pba_pkg::TIME_W-1:0]  now_ms;

	modport source (
		output valid, echo_front_us, echo_left_us, echo_right_us, echo_top_us, now_ms,
		input  ready
	);
	modport sink (
		input  valid, echo_front_us, echo_left_us, echo_right_us, echo_top_us, now_ms,
		output ready
	);
endinterface

interface pba_out_if;
	logic                          valid;
	logic                          ready;
	logic                          buzzer_on;
	logic [pba_pkg::IVL_W-1:0]     beep_interval_ms;
	logic [pba_pkg::DIST_W-1:0]    nearest_distance_cm;
	logic [pba_pkg::SENSOR_W-1:0]  nearest_sensor;

	modport source (
		output valid, buzzer_on, beep_interval_ms, nearest_distance_cm, nearest_sensor,
		input  ready
	);
	modport sink (
		input  valid, buzzer_on, beep_interval_ms, nearest_distance_cm, nearest_sensor,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/pba_front.sv
`default_nettype none

module pba_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	pba_in_if.sink              sensors,
	input  wire pba_pkg::cfg_t  cfg,
	output pba_pkg::job_t       push_job,
	output logic                push_valid,
	input  wire logic           push_ready
);
	import pba_pkg::*;

	fe_state_t state_q, state_nxt;

	logic [ECHO_W-1:0]  echo_q [NUM_SENSORS];
	logic [TIME_W-1:0]  now_q;
	logic [NUM_W-1:0]   best_q;      // running minimum numerator
	logic [IDX_W-1:0]   best_idx_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DIST_W-1:0]  quo_q;

	logic [NUM_W-1:0]   max_num;
	logic [NUM_W-1:0]   warn_num;
	logic [ECHO_W-1:0]  dur;
	logic [NUM_W-1:0]   num;
	logic [NUM_W-1:0]   cand;
	logic [QPROD_W-1:0] quo_prod;

	// Per-sensor distance numerator, clamped to the maximum
	always_comb begin
		max_num  = NUM_W'(cfg.range_cap_cm) * DIST_DEN;
		warn_num = NUM_W'(cfg.warn_limit_cm) * DIST_DEN;
		dur      = echo_q[idx_q];
		num      = NUM_W'(dur) * SOUND_NUM;
		cand     = (dur == '0 || num > max_num) ? max_num : num;
	end

	// Divide by 20000: drop the factor 32, then multiply by a rounded-up 1/625
	always_comb begin
		quo_prod = QPROD_W'(best_q[NUM_W-1:DEN_SH]) * QPROD_W'(RCP_625);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FE_IDLE: if (sensors.valid) state_nxt = FE_SCAN;
			FE_SCAN: if (idx_q == IDX_W'(NUM_SENSORS - 1)) state_nxt = FE_DIV;
			FE_DIV:  state_nxt = FE_PUSH;
			FE_PUSH: if (push_ready) state_nxt = FE_IDLE;
			default: state_nxt = FE_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		sensors.ready   = (state_q == FE_IDLE);
		push_valid      = (state_q == FE_PUSH);
		push_job.now_ms   = now_q;
		push_job.floor_cm = quo_q;
		push_job.sensor   = SENSOR_W'(best_idx_q);
		// beyond warning: numerator strictly above warning*20000
		push_job.silent   = (best_q > warn_num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FE_IDLE: begin
				if (sensors.valid) begin
					echo_q[0]  <= sensors.echo_front_us;
					echo_q[1]  <= sensors.echo_left_us;
					echo_q[2]  <= sensors.echo_right_us;
					echo_q[3]  <= sensors.echo_top_us;
					now_q      <= sensors.now_ms;
					best_q     <= max_num;
					best_idx_q <= '0;
					idx_q      <= '0;
				end
			end
			FE_SCAN: begin
				if (cand < best_q) begin
					best_q     <= cand;
					best_idx_q <= idx_q;
				end
				idx_q <= idx_q + 1'b1;
			end
			FE_DIV: begin
				quo_q <= quo_prod[RCP_SH +: DIST_W];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/pba_queue.sv
`default_nettype none

module pba_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pba_pkg::job_t  push_job,
	input  wire logic           push_valid,
	output logic                push_ready,
	output pba_pkg::job_t       pop_job,
	output logic                pop_valid,
	input  wire logic           pop_ready
);
	import pba_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
		pop_valid  = (count_q != '0);
		pop_job    = mem_q[rd_ptr_q];
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pba_back.sv
`default_nettype none

module pba_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pba_pkg::cfg_t  cfg,
	input  wire pba_pkg::job_t  pop_job,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	pba_out_if.source           alarm
);
	import pba_pkg::*;

	be_state_t state_q, state_nxt;

	job_t              job_q;
	logic [MAG_W-1:0]  mag_q;       // dividend, then quotient magnitude
	logic              neg_q;
	logic [DIST_W-1:0] rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [IVL_W-1:0]  interval_q;
	logic [TIME_W-1:0] last_q;
	logic              beeping_q;
	logic              out_valid_q;
	logic              buzzer_q;
	logic [IVL_W-1:0]  ivl_out_q;
	logic [DIST_W-1:0] dist_out_q;
	logic [SENSOR_W-1:0] sensor_out_q;

	logic [IVL_W-1:0]  abs_diff;
	logic              diff_neg;
	logic [DIST_W:0]   rem_sh;
	logic              div_ge;
	logic [DIST_W:0]   rem_sub;
	logic signed [MAP_W-1:0] quo_s;
	logic signed [MAP_W-1:0] x_s;
	logic signed [MAP_W-1:0] lo_s;
	logic signed [MAP_W-1:0] hi_s;
	logic [IVL_W-1:0]  ivl_map;
	logic [TIME_W-1:0] elapsed;
	logic              beep_nxt;
	logic [TIME_W-1:0] last_nxt;
	logic              out_free;

	// Slope sign and magnitude
	always_comb begin
		diff_neg = (cfg.interval_max_ms < cfg.interval_min_ms);
		abs_diff = diff_neg ? cfg.interval_min_ms - cfg.interval_max_ms
			: cfg.interval_max_ms - cfg.interval_min_ms;
	end

	// One quotient bit per cycle, truncating toward zero on the magnitude
	always_comb begin
		rem_sh  = {rem_q, mag_q[MAG_W-1]};
		div_ge  = (rem_sh >= {1'b0, cfg.warn_limit_cm});
		rem_sub = rem_sh - {1'b0, cfg.warn_limit_cm};
	end

	// Offset and clamp
	always_comb begin
		quo_s = neg_q ? -$signed(MAP_W'(mag_q)) : $signed(MAP_W'(mag_q));
		lo_s  = $signed(MAP_W'(cfg.interval_min_ms));
		hi_s  = $signed(MAP_W'(cfg.interval_max_ms));
		x_s   = quo_s + lo_s;
		if (x_s < lo_s) begin
			ivl_map = cfg.interval_min_ms;
		end else if (x_s > hi_s) begin
			ivl_map = cfg.interval_max_ms;
		end else begin
			ivl_map = x_s[IVL_W-1:0];
		end
	end

	// On/off timer with wrapping time difference
	always_comb begin
		elapsed  = job_q.now_ms - last_q;
		beep_nxt = beeping_q;
		last_nxt = last_q;
		if (interval_q == '0) begin
			beep_nxt = 1'b0;
		end else if (!beeping_q) begin
			if (elapsed >= TIME_W'(interval_q)) begin
				beep_nxt = 1'b1;
				last_nxt = job_q.now_ms;
			end
		end else if (elapsed >= TIME_W'(cfg.beep_on_ms)) begin
			beep_nxt = 1'b0;
			last_nxt = job_q.now_ms;
		end
	end

	assign out_free = !out_valid_q || alarm.ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BE_IDLE: begin
				if (pop_valid) begin
					if (pop_job.silent || cfg.warn_limit_cm == '0) begin
						state_nxt = BE_MAP;
					end else begin
						state_nxt = BE_MUL;
					end
				end
			end
			BE_MUL:   state_nxt = BE_DIV;
			BE_DIV:   if (cnt_q == DCNT_W'(MAG_W - 1)) state_nxt = BE_MAP;
			BE_MAP:   state_nxt = BE_TIMER;
			BE_TIMER: if (out_free) state_nxt = BE_IDLE;
			default:  state_nxt = BE_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop_ready                 = (state_q == BE_IDLE);
		alarm.valid               = out_valid_q;
		alarm.buzzer_on           = buzzer_q;
		alarm.beep_interval_ms    = ivl_out_q;
		alarm.nearest_distance_cm = dist_out_q;
		alarm.nearest_sensor      = sensor_out_q;
	end

	// Control and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			beeping_q   <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == BE_TIMER && out_free) begin
				beeping_q   <= beep_nxt;
				last_q      <= last_nxt;
				out_valid_q <= 1'b1;
			end else if (alarm.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BE_IDLE: begin
				if (pop_valid) begin
					job_q <= pop_job;
					mag_q <= '0;
					neg_q <= 1'b0;
				end
			end
			BE_MUL: begin
				mag_q <= MAG_W'(job_q.floor_cm) * MAG_W'(abs_diff);
				neg_q <= diff_neg;
				rem_q <= '0;
				cnt_q <= '0;
			end
			BE_DIV: begin
				rem_q <= div_ge ? rem_sub[DIST_W-1:0] : rem_sh[DIST_W-1:0];
				mag_q <= {mag_q[MAG_W-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			BE_MAP: begin
				interval_q <= job_q.silent ? '0 : ivl_map;
			end
			BE_TIMER: begin
				if (out_free) begin
					buzzer_q     <= beep_nxt;
					ivl_out_q    <= interval_q;
					dist_out_q   <= job_q.floor_cm;
					sensor_out_q <= job_q.sensor;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/proximity_beep_alarm.sv
// Path from request accept to result valid for an in-range reading:
// front: scan of the four sensors, divide, push; back: pop, multiply, 20-step divide, map, timer.
// Silent requests and a zero warning limit skip the back end's multiply and divide. The front
// takes a new request once its last one is in the queue, so it can work while the back is busy.
// Reset (arst_n low): queue empty, beep state off, toggle time zero, registers at defaults.
`default_nettype none

module proximity_beep_alarm (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pba_in_if.sink                               sensors,
	pba_out_if.source                            alarm,
	input  wire logic                            wr_en,
	input  wire logic [pba_pkg::CFG_IDX_W-1:0]   wr_idx,
	input  wire logic [pba_pkg::CFG_DATA_W-1:0]  wr_data
);
	import pba_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t pop_job;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	// Register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_limit_cm   <= WARNING_RST;
			cfg_q.range_cap_cm    <= MAXDIST_RST;
			cfg_q.beep_on_ms      <= BEEP_ON_RST;
			cfg_q.interval_min_ms <= IVL_MIN_RST;
			cfg_q.interval_max_ms <= IVL_MAX_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_idx))
				REG_WARNING: cfg_q.warn_limit_cm   <= wr_data[DIST_W-1:0];
				REG_MAXDIST: cfg_q.range_cap_cm    <= wr_data[DIST_W-1:0];
				REG_BEEP_ON: cfg_q.beep_on_ms      <= wr_data[ON_W-1:0];
				REG_IVL_MIN: cfg_q.interval_min_ms <= wr_data[IVL_W-1:0];
				REG_IVL_MAX: cfg_q.interval_max_ms <= wr_data[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sensors    (sensors),
		.cfg        (cfg_q),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	pba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	pba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_job   (pop_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.alarm     (alarm)
	);

	// A silent result never sounds the buzzer
	a_silent_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		alarm.valid && alarm.beep_interval_ms == '0 |-> !alarm.buzzer_on)
		else $error("buzzer on with silent interval");

	// The nearest distance never exceeds the clamp
	a_dist_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		alarm.valid |-> alarm.nearest_distance_cm <= cfg_q.range_cap_cm)
		else $error("nearest distance above maximum");

	// Any sensor other than the first only wins with a reading below the clamp
	a_winner_closer: assert property (@(posedge clk) disable iff (!arst_n)
		alarm.valid && alarm.nearest_sensor != '0
			|-> alarm.nearest_distance_cm < cfg_q.range_cap_cm)
		else $error("non-default sensor chosen at clamp distance");

	// Queue push only happens when the front holds a finished request
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !sensors.ready)
		else $error("front pushing while accepting");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
	import pba_pkg::*;

	// Distance arithmetic: echo_us * 343 / 20000 gives cm
	localparam longint unsigned CM_DEN   = 20000;
	localparam longint unsigned ECHO_NUM = 343;
	localparam int ECHO_MAX_US = (1 << ECHO_W) - 1;

	// Register values after reset
	localparam int WARN_RST    = 150;
	localparam int MAXDIST_RST = 200;
	localparam int ON_RST      = 50;
	localparam int IVL_LO_RST  = 30;
	localparam int IVL_HI_RST  = 500;

	// Index past the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_IVL_MAX + 1);

	localparam int RANDOM_PHASES = 9;
	localparam int TAIL_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 1200000;

	typedef struct packed {
		logic                buzzer_on;
		logic [IVL_W-1:0]    beep_interval_ms;
		logic [DIST_W-1:0]   nearest_distance_cm;
		logic [SENSOR_W-1:0] nearest_sensor;
	} alarm_res_t;

	typedef struct packed {
		logic [ECHO_W-1:0] front;
		logic [ECHO_W-1:0] left;
		logic [ECHO_W-1:0] right;
		logic [ECHO_W-1:0] top;
		logic [TIME_W-1:0] now_ms;
		logic              pinned;
		alarm_res_t        res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_idx;
	logic [CFG_DATA_W-1:0] wr_data;

	pba_in_if  sensors_if ();
	pba_out_if alarm_if ();

	proximity_beep_alarm DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensors (sensors_if),
		.alarm   (alarm_if),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	// Predictor copy of the registers and the beep timer
	logic [DIST_W-1:0] warn_cm;
	logic [DIST_W-1:0] max_cm;
	logic [ON_W-1:0]   on_ms;
	logic [IVL_W-1:0]  ivl_lo;
	logic [IVL_W-1:0]  ivl_hi;
	logic [TIME_W-1:0] toggle_ms;
	logic              buzzing;

	alarm_res_t pending_alarms [$];
	stim_row_t  dir_rows [$];

	// Side band for directed rows whose result is typed in
	logic       row_pinned;
	alarm_res_t row_res;

	logic [TIME_W-1:0] clock_ms;
	bit steady;
	int stall_left;
	int mismatches;
	int reqs_accepted;
	int alarms_checked;
	int buzz_seen;
	int silent_seen;
	int settings_used;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Nearest echo, beep interval and on/off timer for one request
	function automatic alarm_res_t beeper_predict(input logic [ECHO_W-1:0] f,
			input logic [ECHO_W-1:0] l, input logic [ECHO_W-1:0] r,
			input logic [ECHO_W-1:0] t, input logic [TIME_W-1:0] now);
		logic [ECHO_W-1:0] echo [NUM_SENSORS];
		longint unsigned ceiling;
		longint unsigned best;
		longint unsigned num;
		longint unsigned floor_cm;
		longint x;
		longint lo;
		longint hi;
		int unsigned idx;
		int unsigned ivl;
		int i;
		logic [TIME_W-1:0] elapsed;
		alarm_res_t res;
		echo[0] = f;
		echo[1] = l;
		echo[2] = r;
		echo[3] = t;
		ceiling = 64'(max_cm) * CM_DEN;
		best = ceiling;
		idx = 0;
		// strict less-than: the first of equal sensors keeps the slot
		for (i = 0; i < NUM_SENSORS; i++) begin
			num = 64'(echo[i]) * ECHO_NUM;
			if (echo[i] == 0 || num > ceiling)
				num = ceiling;
			if (num < best) begin
				best = num;
				idx = i;
			end
		end
		floor_cm = best / CM_DEN;
		if (best > 64'(warn_cm) * CM_DEN) begin
			ivl = 0;
		end else begin
			lo = longint'(ivl_lo);
			hi = longint'(ivl_hi);
			if (warn_cm == 0)
				x = lo;
			else
				x = longint'(floor_cm) * (hi - lo) / longint'(warn_cm) + lo;
			if (x < lo)
				x = lo;
			else if (x > hi)
				x = hi;
			ivl = 32'(x);
		end
		// zero interval counts as silent
		if (ivl == 0) begin
			buzzing = 1'b0;
		end else begin
			elapsed = now - toggle_ms;
			if (!buzzing) begin
				if (elapsed >= ivl) begin
					buzzing = 1'b1;
					toggle_ms = now;
				end
			end else if (elapsed >= 32'(on_ms)) begin
				buzzing = 1'b0;
				toggle_ms = now;
			end
		end
		res.buzzer_on = buzzing;
		res.beep_interval_ms = ivl[IVL_W-1:0];
		res.nearest_distance_cm = floor_cm[DIST_W-1:0];
		res.nearest_sensor = idx[SENSOR_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Register writes, accepted requests and returned alarms, all seen at the rising edge
	always @(posedge clk) begin
		alarm_res_t want;
		alarm_res_t got;
		if (!arst_n) begin
			warn_cm   = WARN_RST;
			max_cm    = MAXDIST_RST;
			on_ms     = ON_RST;
			ivl_lo    = IVL_LO_RST;
			ivl_hi    = IVL_HI_RST;
			toggle_ms = '0;
			buzzing   = 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					REG_WARNING: warn_cm = wr_data[DIST_W-1:0];
					REG_MAXDIST: max_cm = wr_data[DIST_W-1:0];
					REG_BEEP_ON: on_ms = wr_data[ON_W-1:0];
					REG_IVL_MIN: ivl_lo = wr_data[IVL_W-1:0];
					REG_IVL_MAX: ivl_hi = wr_data[IVL_W-1:0];
					default: ;
				endcase
			end
			if (sensors_if.valid && sensors_if.ready) begin
				want = beeper_predict(sensors_if.echo_front_us, sensors_if.echo_left_us,
					sensors_if.echo_right_us, sensors_if.echo_top_us, sensors_if.now_ms);
				pending_alarms.push_back(row_pinned ? row_res : want);
				reqs_accepted++;
			end
			if (alarm_if.valid && alarm_if.ready) begin
				got.buzzer_on = alarm_if.buzzer_on;
				got.beep_interval_ms = alarm_if.beep_interval_ms;
				got.nearest_distance_cm = alarm_if.nearest_distance_cm;
				got.nearest_sensor = alarm_if.nearest_sensor;
				if (pending_alarms.size() == 0) begin
					$display("%0t: alarm result with no request pending (buzzer %0b interval %0d)",
						$time, got.buzzer_on, got.beep_interval_ms);
					mismatches++;
				end else begin
					want = pending_alarms.pop_front();
					check_field("buzzer_on", 32'(want.buzzer_on), 32'(alarm_if.buzzer_on));
					check_field("beep_interval_ms", 32'(want.beep_interval_ms),
						32'(alarm_if.beep_interval_ms));
					check_field("nearest_distance_cm", 32'(want.nearest_distance_cm),
						32'(alarm_if.nearest_distance_cm));
					check_field("nearest_sensor", 32'(want.nearest_sensor),
						32'(alarm_if.nearest_sensor));
					alarms_checked++;
					if (want.buzzer_on)
						buzz_seen++;
					if (want.beep_interval_ms == 0)
						silent_seen++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out, %0d alarms still pending", $time, pending_alarms.size());
			$display("status: fail");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 92)
			return $urandom_range(4, 9);
		return $urandom_range(20, 60);
	endfunction

	// Alarm side back-pressure, with calm stretches
	initial begin
		alarm_if.ready = 1'b0;
		stall_left = 0;
		steady = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 399) == 0)
				steady = !steady;
			if (stall_left > 0) begin
				alarm_if.ready <= 1'b0;
				stall_left--;
			end else begin
				alarm_if.ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 15)
					stall_left = pick_gap();
			end
		end
	end

	function automatic logic [ECHO_W-1:0] pick_echo(input int near_us);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 18)
			return ECHO_W'($urandom_range(0, ECHO_MAX_US));
		else if (r < 28)
			return ECHO_W'($urandom_range(0, 25000));
		return ECHO_W'($urandom_range(1, near_us));
	endfunction

	// Time mostly creeps forward; sometimes jumps, stalls or sits just short of the wrap
	function automatic logic [TIME_W-1:0] next_now(input int step_ms);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			clock_ms = clock_ms + $urandom_range(0, step_ms);
		else if (r < 96 && r >= 88)
			clock_ms = $urandom();
		else if (r >= 96)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_ms);
		return clock_ms;
	endfunction

	task automatic add_row(input int f, input int l, input int r, input int t,
			input logic [TIME_W-1:0] now, input int pinned, input int buz,
			input int ivl, input int near_cm, input int sensor);
		stim_row_t row;
		row.front = ECHO_W'(f);
		row.left = ECHO_W'(l);
		row.right = ECHO_W'(r);
		row.top = ECHO_W'(t);
		row.now_ms = now;
		row.pinned = (pinned != 0);
		row.res.buzzer_on = (buz != 0);
		row.res.beep_interval_ms = IVL_W'(ivl);
		row.res.nearest_distance_cm = DIST_W'(near_cm);
		row.res.nearest_sensor = SENSOR_W'(sensor);
		dir_rows.push_back(row);
	endtask

	// Present one request and hold it until accepted
	task automatic send_req(input stim_row_t row);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap != 0) begin
			sensors_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensors_if.valid         <= 1'b1;
		sensors_if.echo_front_us <= row.front;
		sensors_if.echo_left_us  <= row.left;
		sensors_if.echo_right_us <= row.right;
		sensors_if.echo_top_us   <= row.top;
		sensors_if.now_ms        <= row.now_ms;
		row_pinned               <= row.pinned;
		row_res                  <= row.res;
		do @(posedge clk); while (!sensors_if.ready);
		@(negedge clk);
	endtask

	task automatic random_req(input int near_us, input int step_ms);
		stim_row_t row;
		logic [ECHO_W-1:0] e [NUM_SENSORS];
		int i;
		for (i = 0; i < NUM_SENSORS; i++)
			e[i] = pick_echo(near_us);
		// ties, to exercise first-wins
		if ($urandom_range(0, 9) == 0)
			e[$urandom_range(1, NUM_SENSORS - 1)] = e[$urandom_range(0, NUM_SENSORS - 1)];
		row = '0;
		row.front = e[0];
		row.left = e[1];
		row.right = e[2];
		row.top = e[3];
		row.now_ms = next_now(step_ms);
		send_req(row);
	endtask

	task automatic drain();
		while (pending_alarms.size() != 0)
			@(negedge clk);
	endtask

	// Write every register, junk in the unused upper data bits, then poke the spare index
	task automatic apply_cfg(input int w, input int m, input int on, input int lo,
			input int hi);
		wr_en   <= 1'b1;
		wr_idx  <= REG_WARNING;
		wr_data <= CFG_DATA_W'(($urandom_range(0, 3) << DIST_W) | w);
		@(negedge clk);
		wr_idx  <= REG_MAXDIST;
		wr_data <= CFG_DATA_W'(($urandom_range(0, 3) << DIST_W) | m);
		@(negedge clk);
		wr_idx  <= REG_BEEP_ON;
		wr_data <= CFG_DATA_W'(($urandom_range(0, 1) << ON_W) | on);
		@(negedge clk);
		wr_idx  <= REG_IVL_MIN;
		wr_data <= CFG_DATA_W'(lo);
		@(negedge clk);
		wr_idx  <= REG_IVL_MAX;
		wr_data <= CFG_DATA_W'(hi);
		@(negedge clk);
		wr_idx  <= REG_SPARE;
		wr_data <= CFG_DATA_W'($urandom());
		@(negedge clk);
		wr_en   <= 1'b0;
		settings_used++;
	endtask

	// Quiet the sender, wait for every alarm, reprogram, then run random requests
	task automatic run_phase(input int w, input int m, input int on, input int lo,
			input int hi, input int n);
		int near_us;
		int step_ms;
		int k;
		sensors_if.valid <= 1'b0;
		drain();
		apply_cfg(w, m, on, lo, hi);
		near_us = w * 20000 / 343 + 60;
		if (near_us > ECHO_MAX_US)
			near_us = ECHO_MAX_US;
		step_ms = (lo + hi) / 3 + on + 4;
		for (k = 0; k < n; k++)
			random_req(near_us, step_ms);
	endtask

	function automatic int cfg_pick(input int lo, input int hi, input int width_max);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, width_max);
		return $urandom_range(lo, hi);
	endfunction

	initial begin
		int k;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = REG_WARNING;
		wr_data = '0;
		sensors_if.valid = 1'b0;
		sensors_if.echo_front_us = '0;
		sensors_if.echo_left_us = '0;
		sensors_if.echo_right_us = '0;
		sensors_if.echo_top_us = '0;
		sensors_if.now_ms = '0;
		row_pinned = 1'b0;
		row_res = '0;
		clock_ms = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows under the reset settings
		add_row(0, 0, 0, 0, 0, 1, 0, 0, MAXDIST_RST, 0);        // all timed out
		add_row(ECHO_MAX_US, ECHO_MAX_US, ECHO_MAX_US, ECHO_MAX_US, 1,
			1, 0, 0, MAXDIST_RST, 0);                           // all far, clamped
		add_row(1, 0, 0, 0, 0, 1, 0, IVL_LO_RST, 0, 0);         // closest, timer not due
		add_row(1, 0, 0, 0, 30, 1, 1, IVL_LO_RST, 0, 0);        // interval elapsed, on
		add_row(0, 1, 0, 0, 79, 1, 1, IVL_LO_RST, 0, 1);        // on time not yet spent
		add_row(0, 0, 1, 0, 80, 1, 0, IVL_LO_RST, 0, 2);        // on time spent, off
		add_row(0, 0, 0, 1, 109, 1, 0, IVL_LO_RST, 0, 3);
		add_row(583, 583, 583, 583, 109, 1, 0, 58, 9, 0);       // four-way tie
		add_row(200, 100, 100, 0, 200, 0, 0, 0, 0, 0);
		add_row(8746, 0, 0, 0, 220, 0, 0, 0, 0, 0);             // just inside warning
		add_row(8747, 0, 0, 0, 300, 0, 0, 0, 0, 0);             // just beyond warning
		add_row(11661, 0, 0, 0, 301, 0, 0, 0, 0, 0);            // just under max
		add_row(11662, 0, 0, 0, 302, 0, 0, 0, 0, 0);            // just over max
		add_row(25000, 25000, 25000, 300, 400, 0, 0, 0, 0, 0);
		add_row(300, 299, 0, 0, 401, 0, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 32'hFFFF_FFF0, 0, 0, 0, 0, 0);      // time near wrap
		add_row(1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 32'h0000_0020, 0, 0, 0, 0, 0);      // elapsed across wrap
		add_row(1, 0, 0, 0, 32'h0000_0040, 0, 0, 0, 0, 0);
		add_row(ECHO_MAX_US, 0, 0, 1, 32'h0000_0080, 0, 0, 0, 0, 0);
		add_row(16384, 16384, 16384, 16384, 32'h8000_0000, 0, 0, 0, 0, 0);
		foreach (dir_rows[j])
			send_req(dir_rows[j]);

		// Extremes and corner settings
		run_phase(1, 1, 1, 1, 1, 60);
		run_phase(400, 400, 1000, 1, 2000, 150);
		run_phase(511, 511, 1023, 2047, 2047, 100);
		run_phase(0, 0, 50, 30, 500, 60);          // zero warning with zero max
		run_phase(150, 200, 50, 0, 500, 100);      // zero interval floor
		run_phase(100, 300, 20, 500, 30, 100);     // min above max
		run_phase(0, 200, 0, 30, 500, 40);         // zero warning, zero on time

		for (k = 0; k < RANDOM_PHASES; k++)
			run_phase(cfg_pick(1, 400, 511), cfg_pick(1, 400, 511),
				cfg_pick(1, 1000, 1023), cfg_pick(1, 2000, 2047),
				cfg_pick(1, 2000, 2047), 100);

		sensors_if.valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d requests over %0d register settings, %0d alarms checked, %0d mismatches",
			reqs_accepted, settings_used + 1, alarms_checked, mismatches);
		$display("alarms with buzzer sounding: %0d, silent: %0d, cycles: %0d",
			buzz_seen, silent_seen, cycles);
		if (mismatches == 0 && pending_alarms.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
